>>> rtl/core/vfd_clock_frame_writer_macros.svh
// Assertion helpers for the clock frame writer.
`ifndef VFD_CLOCK_FRAME_WRITER_MACROS_SVH
`define VFD_CLOCK_FRAME_WRITER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define VCFW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define VCFW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/vcfw_pkg.sv
package vcfw_pkg;

	localparam int IMG_BITS = 384;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	// display module codes
	localparam logic [1:0] MOD_A    = 2'd0;
	localparam logic [1:0] MOD_B    = 2'd1;
	localparam logic [1:0] MOD_SEG7 = 2'd2;

	// request kinds
	localparam logic FUNC_CLOCK = 1'b0;
	localparam logic FUNC_LED   = 1'b1;

	// fixed words of the write sequence
	localparam logic [15:0] CTL_ADDR      = 16'h0330;
	localparam logic [15:0] CTL_DATA      = 16'h00f0;
	localparam logic [15:0] CTL_DATA_LAST = 16'h10f0;
	localparam logic [15:0] CTL_DIM       = 16'h1330;
	localparam logic [15:0] CTL_LED       = 16'h1130;
	localparam logic [31:0] DAT_DIM       = 32'h0000_8a0a;
	localparam logic [31:0] DAT_LED_ON    = 32'h0000_1541;
	localparam logic [31:0] DAT_PWR_LED   = 32'h0000_fc41;
	localparam logic [7:0]  ADDR_LOW      = 8'h40;

	typedef struct packed {
		logic       func;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} req_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [15:0] control_word;
		logic        last_write;
	} res_t;

	typedef struct packed {
		logic                func;
		logic [1:0]          mod;
		logic [IMG_BITS-1:0] img;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Segment pattern of digit d placed on the 16 bits of its two image bytes.
	function automatic logic [15:0] digit_pat(logic [1:0] mod, logic [3:0] d);
		logic [13:0] r14;
		logic [6:0]  r7;
		logic [15:0] pat;
		r14 = '0;
		r7  = '0;
		pat = '0;
		case (mod)
			MOD_A: begin
				case (d)
					4'd0: r14 = 14'b10001100000111;
					4'd1: r14 = 14'b00000100000010;
					4'd2: r14 = 14'b10001011000011;
					4'd3: r14 = 14'b10000111000011;
					4'd4: r14 = 14'b00000111000110;
					4'd5: r14 = 14'b10000111000101;
					4'd6: r14 = 14'b10001111000100;
					4'd7: r14 = 14'b00000100000011;
					4'd8: r14 = 14'b10001111000111;
					default: r14 = 14'b00000111000111;
				endcase
				pat = {1'b0, r14, 1'b0};
			end
			MOD_B: begin
				case (d)
					4'd0: r14 = 14'b11100000000111;
					4'd1: r14 = 14'b01000000000010;
					4'd2: r14 = 14'b10100011000011;
					4'd3: r14 = 14'b11000011000011;
					4'd4: r14 = 14'b01000011000110;
					4'd5: r14 = 14'b11000011000101;
					4'd6: r14 = 14'b11100011000100;
					4'd7: r14 = 14'b01000000000011;
					4'd8: r14 = 14'b11100011000111;
					default: r14 = 14'b01000011000111;
				endcase
				pat = {2'b00, r14};
			end
			default: begin
				case (d)
					4'd0: r7 = 7'b1110111;
					4'd1: r7 = 7'b0100010;
					4'd2: r7 = 7'b1011011;
					4'd3: r7 = 7'b1101011;
					4'd4: r7 = 7'b0101110;
					4'd5: r7 = 7'b1101101;
					4'd6: r7 = 7'b1111100;
					4'd7: r7 = 7'b0100011;
					4'd8: r7 = 7'b1111111;
					default: r7 = 7'b0101111;
				endcase
				pat = {9'd0, r7};
			end
		endcase
		return pat;
	endfunction

endpackage

>>> rtl/core/vfd_clock_frame_writer.sv
// Clock frame writer: turns a time of day or a power-LED request into the
// register write sequence of a vacuum fluorescent clock display.
// Request channel: drive req and raise start; the item is taken at a rising
// edge where start is high and busy is low. busy rises only while the front
// holds an item and the two-entry queue to the sequencer is full.
// Result channel: each register write appears on result for exactly one
// cycle with strobe high; the receiver cannot stall it, so results are
// never held off and never dropped.
// Configuration: module_type_we/module_type_wdata write the module type;
// write it only while the block is idle.
// Sequence: an accepted item passes the front stage register, the queue,
// the sequencer state and the output register before its first write shows.
// A refresh emits 16 writes (17 on the seven-segment module), a power-LED
// request one write, at one write per cycle; the write sequencer sets the
// throughput, and queued items follow back to back with no gap.
// Reset (arst_n low) empties the front stage, queue and sequencer and
// sets the module type to fourteen-segment A.
`include "vfd_clock_frame_writer_macros.svh"

module vfd_clock_frame_writer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  vcfw_pkg::req_t req,
	input  logic           module_type_we,
	input  logic [1:0]     module_type_wdata,
	output logic           strobe,
	output vcfw_pkg::res_t result
);

	logic [1:0]        module_type_q;
	vcfw_pkg::q_stat_t qstat;
	vcfw_pkg::entry_t  fe_entry;
	vcfw_pkg::entry_t  q_head;
	logic              q_push;
	logic              q_pop;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_type_q <= vcfw_pkg::MOD_A;
		end else if (module_type_we) begin
			module_type_q <= module_type_wdata;
		end
	end

	// front: take the item, saturate, build the segment image
	vcfw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.module_type (module_type_q),
		.qstat       (qstat),
		.push        (q_push),
		.entry       (fe_entry)
	);

	// decouples the front from the write sequencer
	vcfw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (fe_entry),
		.pop      (q_pop),
		.rd_entry (q_head),
		.qstat    (qstat)
	);

	// back: steps through the writes of one queued item
	vcfw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (q_head),
		.pop    (q_pop),
		.strobe (strobe),
		.result (result)
	);

	// queue flow must never overrun or underrun
	`VCFW_ASSERT_IMP(a_no_push_full, q_push, !qstat.full, "push into full queue")
	`VCFW_ASSERT_IMP(a_no_pop_empty, q_pop, !qstat.empty, "pop from empty queue")
	// a taken item keeps the front occupied or is pushed on the next cycle
	`VCFW_ASSERT_NXT(a_accept_held, start && !busy, !qstat.empty || busy || q_push,
		"accepted item lost")
	// the power-LED word always closes its sequence
	`VCFW_ASSERT_IMP(a_pwr_last, strobe && result.data_word == vcfw_pkg::DAT_PWR_LED,
		result.last_write, "power LED write not last")

endmodule

>>> rtl/core/vcfw_front.sv
module vcfw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vcfw_pkg::req_t     req,
	input  logic [1:0]         module_type,
	input  vcfw_pkg::q_stat_t  qstat,
	output logic               push,
	output vcfw_pkg::entry_t   entry
);

	// byte offsets of the digits
	localparam int OFF_HT  = 18;
	localparam int OFF_HO  = 15;
	localparam int OFF_MT  = 12;
	localparam int OFF_MO  = 9;
	localparam int OFF_ST  = 6;
	localparam int OFF_SO  = 3;
	localparam int OFF7_HT = 28;
	localparam int OFF7_HO = 27;
	localparam int OFF7_MT = 31;
	localparam int OFF7_MO = 30;

	logic           valid_s1;
	vcfw_pkg::req_t req_s1;
	logic [1:0]     mod_s1;
	logic           accept;

	logic [4:0] hr;
	logic [5:0] mn;
	logic [5:0] sc_full;
	logic [4:0] sc;
	logic [3:0] hr_t, hr_o, mn_t, mn_o, sc_t, sc_o;
	logic [vcfw_pkg::IMG_BITS-1:0] img;

	assign busy   = valid_s1 && qstat.full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			mod_s1 <= (module_type > vcfw_pkg::MOD_SEG7) ? vcfw_pkg::MOD_SEG7 : module_type;
		end
	end

	// saturate, halve the seconds and split into decimal digits
	always_comb begin
		hr      = (req_s1.hour > 5'd23) ? 5'd23 : req_s1.hour;
		mn      = (req_s1.minute > 6'd59) ? 6'd59 : req_s1.minute;
		sc_full = (req_s1.second > 6'd59) ? 6'd59 : req_s1.second;
		sc      = sc_full[5:1];

		if (hr >= 5'd20) begin
			hr_t = 4'd2; hr_o = 4'(hr - 5'd20);
		end else if (hr >= 5'd10) begin
			hr_t = 4'd1; hr_o = 4'(hr - 5'd10);
		end else begin
			hr_t = 4'd0; hr_o = hr[3:0];
		end

		if (mn >= 6'd50) begin
			mn_t = 4'd5; mn_o = 4'(mn - 6'd50);
		end else if (mn >= 6'd40) begin
			mn_t = 4'd4; mn_o = 4'(mn - 6'd40);
		end else if (mn >= 6'd30) begin
			mn_t = 4'd3; mn_o = 4'(mn - 6'd30);
		end else if (mn >= 6'd20) begin
			mn_t = 4'd2; mn_o = 4'(mn - 6'd20);
		end else if (mn >= 6'd10) begin
			mn_t = 4'd1; mn_o = 4'(mn - 6'd10);
		end else begin
			mn_t = 4'd0; mn_o = mn[3:0];
		end

		if (sc >= 5'd20) begin
			sc_t = 4'd2; sc_o = 4'(sc - 5'd20);
		end else if (sc >= 5'd10) begin
			sc_t = 4'd1; sc_o = 4'(sc - 5'd10);
		end else begin
			sc_t = 4'd0; sc_o = sc[3:0];
		end
	end

	// segment image; digit windows never overlap the colon bits, so OR is enough
	always_comb begin
		img = '0;
		case (mod_s1)
			vcfw_pkg::MOD_A, vcfw_pkg::MOD_B: begin
				img[OFF_HT*8 +: 16] = img[OFF_HT*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, hr_t);
				img[OFF_HO*8 +: 16] = img[OFF_HO*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, hr_o);
				img[OFF_MT*8 +: 16] = img[OFF_MT*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, mn_t);
				img[OFF_MO*8 +: 16] = img[OFF_MO*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, mn_o);
				if (mod_s1 == vcfw_pkg::MOD_A) begin
					img[OFF_ST*8 +: 16] = img[OFF_ST*8 +: 16] |
						vcfw_pkg::digit_pat(mod_s1, sc_t);
					img[OFF_SO*8 +: 16] = img[OFF_SO*8 +: 16] |
						vcfw_pkg::digit_pat(mod_s1, sc_o);
					img[16*8 + 7] = 1'b1;
					img[10*8 + 7] = 1'b1;
				end else begin
					img[16*8 + 6] = 1'b1;
				end
			end
			default: begin
				img[OFF7_HT*8 +: 16] = img[OFF7_HT*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, hr_t);
				img[OFF7_HO*8 +: 16] = img[OFF7_HO*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, hr_o);
				img[OFF7_MT*8 +: 16] = img[OFF7_MT*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, mn_t);
				img[OFF7_MO*8 +: 16] = img[OFF7_MO*8 +: 16] | vcfw_pkg::digit_pat(mod_s1, mn_o);
				// colon blinks on the halved second
				if (!sc[0]) begin
					img[27*8 + 7] = 1'b1;
				end
			end
		endcase
	end

	assign entry.func = req_s1.func;
	assign entry.mod  = mod_s1;
	assign entry.img  = img;

endmodule

>>> rtl/core/vcfw_queue.sv
module vcfw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vcfw_pkg::entry_t  wr_entry,
	input  logic              pop,
	output vcfw_pkg::entry_t  rd_entry,
	output vcfw_pkg::q_stat_t qstat
);

	vcfw_pkg::entry_t mem_q [vcfw_pkg::Q_DEPTH];
	logic [vcfw_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [vcfw_pkg::Q_CNT_W-1:0] cnt_q;

	function automatic logic [vcfw_pkg::Q_PTR_W-1:0] ptr_inc(
		logic [vcfw_pkg::Q_PTR_W-1:0] p);
		return (p == vcfw_pkg::Q_PTR_W'(vcfw_pkg::Q_DEPTH - 1)) ? '0 :
			vcfw_pkg::Q_PTR_W'(p + 1'b1);
	endfunction

	assign qstat.full  = (cnt_q == vcfw_pkg::Q_CNT_W'(vcfw_pkg::Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rd_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

>>> rtl/core/vcfw_back.sv
module vcfw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  vcfw_pkg::q_stat_t qstat,
	input  vcfw_pkg::entry_t  head,
	output logic              pop,
	output logic              strobe,
	output vcfw_pkg::res_t    result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BANK = 3'd1;
	localparam logic [2:0] ST_DIM  = 3'd2;
	localparam logic [2:0] ST_LED  = 3'd3;
	localparam logic [2:0] ST_PWR  = 3'd4;

	logic [2:0] st_q;
	logic [1:0] bank_q;
	logic [2:0] slot_q;
	logic [1:0] mod_q;
	logic [vcfw_pkg::IMG_BITS-1:0] img_q;
	logic           strobe_q;
	vcfw_pkg::res_t res_q;
	vcfw_pkg::res_t res_d;
	logic           finishing;
	logic [1:0]     wj;
	logic [3:0]     widx;

	assign finishing = (st_q == ST_PWR) || (st_q == ST_LED) ||
		((st_q == ST_DIM) && (mod_q != vcfw_pkg::MOD_SEG7));
	assign pop = ((st_q == ST_IDLE) || finishing) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			bank_q <= '0;
			slot_q <= '0;
		end else if (pop) begin
			st_q   <= (head.func == vcfw_pkg::FUNC_LED) ? ST_PWR : ST_BANK;
			bank_q <= '0;
			slot_q <= '0;
		end else if (finishing) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_BANK: begin
					if (slot_q == 3'd4) begin
						slot_q <= '0;
						if (bank_q == 2'd2) begin
							st_q <= ST_DIM;
						end else begin
							bank_q <= bank_q + 1'b1;
						end
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_DIM: st_q <= ST_LED;
				default: st_q <= st_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mod_q <= head.mod;
			img_q <= head.img;
		end
	end

	assign wj   = 2'(slot_q - 3'd1);
	assign widx = {bank_q, wj};

	always_comb begin
		res_d = '0;
		case (st_q)
			ST_BANK: begin
				if (slot_q == 3'd0) begin
					res_d.data_word    = {16'h0000, 2'b11, bank_q, 4'h0, vcfw_pkg::ADDR_LOW};
					res_d.control_word = vcfw_pkg::CTL_ADDR;
				end else begin
					res_d.data_word    = img_q[{widx, 5'd0} +: 32];
					res_d.control_word = (wj == 2'd3) ? vcfw_pkg::CTL_DATA_LAST :
						vcfw_pkg::CTL_DATA;
				end
			end
			ST_DIM: begin
				res_d.data_word    = vcfw_pkg::DAT_DIM;
				res_d.control_word = vcfw_pkg::CTL_DIM;
				res_d.last_write   = (mod_q != vcfw_pkg::MOD_SEG7);
			end
			ST_LED: begin
				res_d.data_word    = vcfw_pkg::DAT_LED_ON;
				res_d.control_word = vcfw_pkg::CTL_LED;
				res_d.last_write   = 1'b1;
			end
			ST_PWR: begin
				res_d.data_word    = vcfw_pkg::DAT_PWR_LED;
				res_d.control_word = vcfw_pkg::CTL_LED;
				res_d.last_write   = 1'b1;
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (st_q != ST_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

>>> test/vfd_frame_checker.sv
module vfd_frame_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  vcfw_pkg::req_t req,
	input  logic           module_type_we,
	input  logic [1:0]     module_type_wdata,
	input  logic           strobe,
	input  vcfw_pkg::res_t result,
	output int             fail_count,
	output int             outstanding
);
	import vcfw_pkg::*;

	logic [1:0] module_sel;
	logic [7:0] frame [48];
	res_t       write_q [$];
	int         mismatches = 0;

	// segment row of one digit; bit k drives the k-th lit position of the digit
	function automatic logic [13:0] seg_row(logic [1:0] m, int d);
		if (m == MOD_A) begin
			case (d)
				0: return 14'b10001100000111;
				1: return 14'b00000100000010;
				2: return 14'b10001011000011;
				3: return 14'b10000111000011;
				4: return 14'b00000111000110;
				5: return 14'b10000111000101;
				6: return 14'b10001111000100;
				7: return 14'b00000100000011;
				8: return 14'b10001111000111;
				default: return 14'b00000111000111;
			endcase
		end else if (m == MOD_B) begin
			case (d)
				0: return 14'b11100000000111;
				1: return 14'b01000000000010;
				2: return 14'b10100011000011;
				3: return 14'b11000011000011;
				4: return 14'b01000011000110;
				5: return 14'b11000011000101;
				6: return 14'b11100011000100;
				7: return 14'b01000000000011;
				8: return 14'b11100011000111;
				default: return 14'b01000011000111;
			endcase
		end else begin
			case (d)
				0: return {7'd0, 7'b1110111};
				1: return {7'd0, 7'b0100010};
				2: return {7'd0, 7'b1011011};
				3: return {7'd0, 7'b1101011};
				4: return {7'd0, 7'b0101110};
				5: return {7'd0, 7'b1101101};
				6: return {7'd0, 7'b1111100};
				7: return {7'd0, 7'b0100011};
				8: return {7'd0, 7'b1111111};
				default: return {7'd0, 7'b0101111};
			endcase
		end
	endfunction

	// digit spans bytes off and off+1; positions outside lo..hi are untouched
	task automatic draw_digit(input int off, input int d, input logic [1:0] m);
		logic [13:0] row;
		int lo, hi, idx, p;
		row = seg_row(m, d);
		lo = (m == MOD_A) ? 1 : 0;
		hi = (m == MOD_A) ? 14 : (m == MOD_B) ? 13 : 6;
		for (p = lo; p <= hi; p++) begin
			idx = (off + p / 8) % 48;
			frame[idx][p % 8] = row[p - lo];
		end
	endtask

	task automatic predict_writes(input req_t r);
		res_t       seq [17];
		logic [1:0] m;
		logic [7:0] bank_hi;
		int         n, h, mi, s, a, b, j, i;
		n = 0;
		if (r.func == FUNC_LED) begin
			seq[0].data_word    = DAT_PWR_LED;
			seq[0].control_word = CTL_LED;
			n = 1;
		end else begin
			m  = (module_sel > MOD_SEG7) ? MOD_SEG7 : module_sel;
			h  = (r.hour > 23) ? 23 : r.hour;
			mi = (r.minute > 59) ? 59 : r.minute;
			s  = ((r.second > 59) ? 59 : r.second) / 2;
			for (i = 0; i < 48; i++)
				frame[i] = 8'h00;
			if (m == MOD_A) begin
				frame[16][7] = 1'b1;
				frame[10][7] = 1'b1;
			end else if (m == MOD_B) begin
				frame[16][6] = 1'b1;
			end else if (s % 2 == 0) begin
				frame[27][7] = 1'b1;
			end
			if (m == MOD_SEG7) begin
				draw_digit(28, h / 10, m);
				draw_digit(27, h % 10, m);
				draw_digit(31, mi / 10, m);
				draw_digit(30, mi % 10, m);
			end else begin
				draw_digit(18, h / 10, m);
				draw_digit(15, h % 10, m);
				draw_digit(12, mi / 10, m);
				draw_digit(9, mi % 10, m);
				if (m == MOD_A) begin
					draw_digit(6, s / 10, m);
					draw_digit(3, s % 10, m);
				end
			end
			for (b = 0; b < 3; b++) begin
				bank_hi = 8'hc0 | 8'(16 * b);
				seq[n].data_word    = {16'd0, bank_hi, ADDR_LOW};
				seq[n].control_word = CTL_ADDR;
				n++;
				for (j = 0; j < 4; j++) begin
					a = 16 * b + 4 * j;
					seq[n].data_word    = {frame[a + 3], frame[a + 2], frame[a + 1], frame[a]};
					seq[n].control_word = (j < 3) ? CTL_DATA : CTL_DATA_LAST;
					n++;
				end
			end
			seq[n].data_word    = DAT_DIM;
			seq[n].control_word = CTL_DIM;
			n++;
			if (m == MOD_SEG7) begin
				seq[n].data_word    = DAT_LED_ON;
				seq[n].control_word = CTL_LED;
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			seq[i].last_write = (i == n - 1);
			write_q.push_back(seq[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			module_sel = MOD_A;
			write_q.delete();
		end else begin
			// writes out before new item in: the same edge cannot carry both ends
			if (strobe !== 1'b0) begin
				if (write_q.size() == 0) begin
					mismatches++;
					$error("unexpected write: data_word %h control_word %h",
						result.data_word, result.control_word);
				end else begin
					want = write_q.pop_front();
					if (want.data_word !== result.data_word) begin
						mismatches++;
						$error("data_word: expected %h, got %h",
							want.data_word, result.data_word);
					end
					if (want.control_word !== result.control_word) begin
						mismatches++;
						$error("control_word: expected %h, got %h",
							want.control_word, result.control_word);
					end
					if (want.last_write !== result.last_write) begin
						mismatches++;
						$error("last_write: expected %b, got %b",
							want.last_write, result.last_write);
					end
				end
			end
			if (module_type_we === 1'b1)
				module_sel = module_type_wdata;
			if (start === 1'b1 && busy === 1'b0)
				predict_writes(req);
		end
		fail_count  <= mismatches;
		outstanding <= write_q.size();
	end

endmodule

>>> test/tb.sv
// Clock frame writer bench: drives time and power-LED requests through the
// start/busy handshake, while a separate checker predicts every register
// write and compares the strobed results. This module only makes stimulus,
// moves module_type between phases and gives the verdict.
module tb;
	import vcfw_pkg::*;

	// module_type code outside the documented range; the block treats it as
	// the seven-segment module
	localparam logic [1:0] MOD_RESERVED = 2'd3;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int SEG_ITEMS    = 30;
	localparam int SEG_COUNT    = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       module_type_we = 1'b0;
	logic [1:0] module_type_wdata = 2'd0;
	logic       strobe;
	res_t       result;

	int fail_count;
	int outstanding;
	int n_items = 0;
	int n_led = 0;
	int cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vfd_clock_frame_writer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req              (req),
		.module_type_we   (module_type_we),
		.module_type_wdata(module_type_wdata),
		.strobe           (strobe),
		.result           (result)
	);

	vfd_frame_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req              (req),
		.module_type_we   (module_type_we),
		.module_type_wdata(module_type_wdata),
		.strobe           (strobe),
		.result           (result),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	function automatic req_t make_req(logic f, int h, int m, int s);
		req_t r;
		r.func   = f;
		r.hour   = 5'(h);
		r.minute = 6'(m);
		r.second = 6'(s);
		return r;
	endfunction

	// Mostly legal times; about one field in eight lands in the saturating
	// range so the top bits of every field toggle. Power-LED requests are
	// kept rare since they skip the whole frame.
	function automatic req_t random_request();
		req_t r;
		r.func   = ($urandom_range(6) == 0) ? FUNC_LED : FUNC_CLOCK;
		r.hour   = ($urandom_range(7) == 0) ? 5'($urandom_range(31, 24)) :
			5'($urandom_range(23, 0));
		r.minute = ($urandom_range(7) == 0) ? 6'($urandom_range(63, 60)) :
			6'($urandom_range(59, 0));
		r.second = ($urandom_range(7) == 0) ? 6'($urandom_range(63, 60)) :
			6'($urandom_range(59, 0));
		return r;
	endfunction

	// Gap cycles first (start low), then hold start until an edge with busy
	// low takes the item. start is left high on return: the next call either
	// lowers it in a gap or keeps it up for a back-to-back item, so start
	// never sees two assignments in one step.
	task automatic send_item(input req_t r, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
		if (r.func == FUNC_LED) n_led++;
	endtask

	// Stop sending and wait until every predicted write has come out. The
	// first edge lets the checker's count include the item just taken.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_module(input logic [1:0] m);
		wait_idle();
		module_type_we    <= 1'b1;
		module_type_wdata <= m;
		@(posedge clk);
		module_type_we <= 1'b0;
	endtask

	// Directed corners per module: zero time, last legal time, saturation,
	// power-LED request, and on the seven-segment module both colon states
	// (halved second even / odd).
	task automatic run_directed();
		// module A straight out of reset
		send_item(make_req(FUNC_CLOCK, 0, 0, 0), 12);
		send_item(make_req(FUNC_CLOCK, 23, 59, 59), 12);
		send_item(make_req(FUNC_CLOCK, 31, 63, 63), 12);
		send_item(make_req(FUNC_CLOCK, 12, 34, 56), 0);
		send_item(make_req(FUNC_LED, 31, 63, 63), 0);
		send_item(make_req(FUNC_CLOCK, 19, 8, 7), 0);

		set_module(MOD_B);
		send_item(make_req(FUNC_CLOCK, 0, 0, 0), 12);
		send_item(make_req(FUNC_CLOCK, 23, 59, 59), 0);
		send_item(make_req(FUNC_CLOCK, 24, 60, 60), 0);
		send_item(make_req(FUNC_CLOCK, 9, 45, 18), 12);
		send_item(make_req(FUNC_LED, 0, 0, 0), 0);

		set_module(MOD_SEG7);
		send_item(make_req(FUNC_CLOCK, 10, 20, 0), 0);   // colon lit
		send_item(make_req(FUNC_CLOCK, 10, 20, 2), 0);   // colon dark
		send_item(make_req(FUNC_CLOCK, 31, 63, 63), 12); // saturates, odd -> dark
		send_item(make_req(FUNC_CLOCK, 23, 59, 58), 0);
		send_item(make_req(FUNC_CLOCK, 7, 36, 4), 0);
		send_item(make_req(FUNC_CLOCK, 0, 0, 1), 12);
		send_item(make_req(FUNC_LED, 23, 59, 59), 0);

		set_module(MOD_RESERVED);
		send_item(make_req(FUNC_CLOCK, 31, 63, 63), 0);
		send_item(make_req(FUNC_CLOCK, 15, 51, 40), 0);
		send_item(make_req(FUNC_LED, 15, 51, 40), 0);
	endtask

	// Watchdog: the slowest legal run is far below this many cycles.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("vfd_clock_frame_writer verification failed");
		$finish;
	end

	initial begin
		int seg, k, pct;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Random phases: sender idles 12% for two phases, 69% for two,
		// then never. Each phase runs under its own module_type.
		for (seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg)
				0: set_module(MOD_SEG7);
				1: set_module(MOD_A);
				2: set_module(MOD_B);
				3: set_module(MOD_RESERVED);
				4: set_module(MOD_A);
				default: set_module(MOD_SEG7);
			endcase
			pct = (seg < 2) ? 12 : (seg < 4) ? 69 : 0;
			for (k = 0; k < SEG_ITEMS; k++) begin
				// full drain in the middle of a phase, then resume
				if (seg == 4 && k == SEG_ITEMS / 2)
					wait_idle();
				send_item(random_request(), pct);
			end
		end

		wait_idle();

		$display("covered %0d requests (%0d power-LED) under all four module_type codes",
			n_items, n_led);
		$display("sender gaps of 12%% and 69%%, back-to-back traffic, and a mid-run drain");
		if (fail_count == 0 && outstanding == 0) begin
			$display("vfd_clock_frame_writer verification clean");
		end else begin
			$display("vfd_clock_frame_writer verification failed");
		end
		$finish;
	end

endmodule
